/* rtl/lcdt_pkg.sv */
// Shared types and constants for the LCD mode and line timer.
package lcdt_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_RENDER = 2'd3
  } lcdt_mode_e;

  typedef enum logic {
    CFG_LINE_LENGTH  = 1'b0,
    CFG_FRAME_LENGTH = 1'b1
  } lcdt_cfg_e;

  localparam int unsigned LineLenW  = 10;
  localparam int unsigned FrameLenW = 17;
  localparam int unsigned LineCdW   = 11;
  localparam int unsigned FrameCdW  = 18;

  localparam logic [LineLenW-1:0]  LINE_LENGTH_RST  = 10'd456;
  localparam logic [FrameLenW-1:0] FRAME_LENGTH_RST = 17'd70224;

  localparam logic signed [LineCdW:0]   LINE_CD_MIN  = -12'sd1024;
  localparam logic signed [FrameCdW:0]  FRAME_CD_MIN = -19'sd131072;
  localparam logic signed [LineCdW-1:0] OAM_START    = 11'sd376;
  localparam logic signed [LineCdW-1:0] RENDER_END   = 11'sd85;

  localparam logic [7:0] VBLANK_FIRST_LINE = 8'd144;
  localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;

  typedef struct packed {
    logic [9:0] cycles;
    logic       lcd_enable;
    logic [7:0] compare_line;
    logic       irq_en_hblank;
    logic       irq_en_vblank;
    logic       irq_en_oam;
    logic       irq_en_match;
  } lcdt_in_t;

  typedef struct packed {
    lcdt_mode_e                  mode;
    logic                        match_flag;
    logic [7:0]                  line_counter;
    logic signed [LineCdW-1:0]   line_countdown;
    logic signed [FrameCdW-1:0]  frame_countdown;
  } lcdt_state_t;

  typedef struct packed {
    lcdt_mode_e mode;
    logic       coincidence;
    logic [7:0] visible_line;
    logic       lcd_irq;
    logic       vblank_irq;
    logic       draw_strobe;
    logic [7:0] draw_line_number;
    logic       frame_complete;
  } lcdt_result_t;

endpackage

/* rtl/lcdt_step.sv */
// Next-state and result logic for one timer tick.
module lcdt_step import lcdt_pkg::*; (
  input  lcdt_state_t           state_i,
  input  lcdt_in_t              item_i,
  input  logic [LineLenW-1:0]   line_length_i,
  input  logic [FrameLenW-1:0]  frame_length_i,
  output lcdt_state_t           state_o,
  output lcdt_result_t          result_o
);

  logic signed [LineCdW:0]    ticks_line;
  logic signed [FrameCdW:0]   ticks_frame;
  logic signed [LineCdW:0]    line_sub;
  logic signed [FrameCdW:0]   frame_sub;
  logic signed [LineCdW-1:0]  line_cd;
  logic signed [FrameCdW-1:0] frame_cd;
  logic signed [LineCdW:0]    line_reload;
  logic signed [FrameCdW:0]   frame_reload;
  logic                       line_expired;
  logic                       frame_expired;
  logic [7:0]                 line_next;

  always_comb begin
    ticks_line  = $signed({4'b0000, item_i.cycles[9:2]});
    ticks_frame = $signed({11'b0, item_i.cycles[9:2]});
    line_sub    = $signed({state_i.line_countdown[LineCdW-1], state_i.line_countdown})
                  - ticks_line;
    frame_sub   = $signed({state_i.frame_countdown[FrameCdW-1], state_i.frame_countdown})
                  - ticks_frame;
    line_cd  = (line_sub < LINE_CD_MIN) ? LINE_CD_MIN[LineCdW-1:0] : line_sub[LineCdW-1:0];
    frame_cd = (frame_sub < FRAME_CD_MIN) ? FRAME_CD_MIN[FrameCdW-1:0]
                                          : frame_sub[FrameCdW-1:0];
    line_expired  = line_cd[LineCdW-1] || (line_cd == '0);
    frame_expired = frame_cd[FrameCdW-1] || (frame_cd == '0);
    line_reload   = $signed({line_cd[LineCdW-1], line_cd})
                    + $signed({2'b00, line_length_i});
    frame_reload  = $signed({frame_cd[FrameCdW-1], frame_cd})
                    + $signed({2'b00, frame_length_i});
    line_next = state_i.line_counter + 8'd1;

    state_o  = state_i;
    result_o = '0;
    state_o.line_countdown  = line_cd;
    state_o.frame_countdown = frame_cd;

    // Mode follows the line and where the line timer stands.
    if (item_i.lcd_enable) begin
      if (state_i.line_counter >= VBLANK_FIRST_LINE) begin
        state_o.mode = MODE_VBLANK;
      end else if (line_cd >= OAM_START) begin
        if (item_i.irq_en_oam && (state_i.mode != MODE_OAM)) result_o.lcd_irq = 1'b1;
        state_o.mode = MODE_OAM;
      end else if (line_cd >= RENDER_END) begin
        state_o.mode = MODE_RENDER;
      end else begin
        if (item_i.irq_en_hblank && (state_i.mode != MODE_HBLANK)) result_o.lcd_irq = 1'b1;
        state_o.mode = MODE_HBLANK;
      end
    end else begin
      state_o.mode = MODE_HBLANK;
    end

    if (line_expired) begin
      if (state_i.line_counter <= LAST_VISIBLE_LINE) begin
        result_o.draw_strobe      = 1'b1;
        result_o.draw_line_number = state_i.line_counter;
      end
      if (state_i.line_counter == LAST_VISIBLE_LINE) begin
        result_o.frame_complete = 1'b1;
        if (item_i.lcd_enable) begin
          result_o.vblank_irq = 1'b1;
          if (item_i.irq_en_vblank) result_o.lcd_irq = 1'b1;
        end
      end
      state_o.line_counter = line_next;
      if (item_i.lcd_enable) begin
        state_o.match_flag = (item_i.compare_line == line_next);
        if ((item_i.compare_line == line_next) && item_i.irq_en_match) begin
          result_o.lcd_irq = 1'b1;
        end
      end
      state_o.line_countdown = line_reload[LineCdW-1:0];
    end

    if (frame_expired) begin
      state_o.line_counter    = 8'd0;
      state_o.frame_countdown = frame_reload[FrameCdW-1:0];
    end

    result_o.mode         = state_o.mode;
    result_o.coincidence  = state_o.match_flag;
    result_o.visible_line = item_i.lcd_enable ? state_o.line_counter : 8'd0;
  end

endmodule

/* rtl/lcd_mode_and_line_timer.sv */
// Top level of the LCD mode and line timer: state, configuration and output register.
//
// Each input transfer carries one tick: the elapsed CPU time (cycles_i), the LCD enable
// bit, the line compare value and the four status interrupt enables. The tick
// is divided by four and counted down on a line timer and a frame timer; each
// transfer yields exactly one result transfer with the display mode, the
// coincidence flag, the current line, interrupt requests, the line drawing
// strobe and frame done.
//
// A tick taken at a clock edge has its result in the output register right
// after that edge. The block takes one tick per clock while the receiver does
// not stall; the state update is a single pass of subtract, compare and
// reload logic, and the output register lets the next tick enter while a
// result is taken. When the receiver stalls, the result holds and in_stall_o
// rises, so no further tick is taken until the result moves on.
//
// Reset clears the mode, flag and line counter, loads the lengths with their
// defaults (456 and 70224) and loads the timers from them. Length writes on
// the configuration port take effect at the next reload of the timer.
module lcd_mode_and_line_timer import lcdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [9:0]  cycles_i,
  input  logic        lcd_enable_i,
  input  logic [7:0]  compare_line_i,
  input  logic        irq_en_hblank_i,
  input  logic        irq_en_vblank_i,
  input  logic        irq_en_oam_i,
  input  logic        irq_en_match_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  mode_o,
  output logic        coincidence_o,
  output logic [7:0]  visible_line_o,
  output logic        lcd_irq_o,
  output logic        vblank_irq_o,
  output logic        draw_strobe_o,
  output logic [7:0]  draw_line_number_o,
  output logic        frame_complete_o
);

  logic [LineLenW-1:0]  line_length_q;
  logic [FrameLenW-1:0] frame_length_q;
  lcdt_state_t          state_q, state_d;
  lcdt_result_t         result_q, result_d;
  lcdt_in_t             item;
  logic                 out_valid_q;
  logic                 in_xfer;

  // A tick may enter whenever the output register is empty or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign item = '{cycles:        cycles_i,
                  lcd_enable:    lcd_enable_i,
                  compare_line:  compare_line_i,
                  irq_en_hblank: irq_en_hblank_i,
                  irq_en_vblank: irq_en_vblank_i,
                  irq_en_oam:    irq_en_oam_i,
                  irq_en_match:  irq_en_match_i};

  lcdt_step u_step (
    .state_i        (state_q),
    .item_i         (item),
    .line_length_i  (line_length_q),
    .frame_length_i (frame_length_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q  <= LINE_LENGTH_RST;
      frame_length_q <= FRAME_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (lcdt_cfg_e'(cfg_idx_i))
        CFG_LINE_LENGTH:  line_length_q  <= cfg_wdata_i[LineLenW-1:0];
        CFG_FRAME_LENGTH: frame_length_q <= cfg_wdata_i[FrameLenW-1:0];
        default: ;
      endcase
    end
  end

  // Timer state advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode            <= MODE_HBLANK;
      state_q.match_flag      <= 1'b0;
      state_q.line_counter    <= 8'd0;
      state_q.line_countdown  <= {1'b0, LINE_LENGTH_RST};
      state_q.frame_countdown <= {1'b0, FRAME_LENGTH_RST};
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The result payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mode_o             = result_q.mode;
  assign coincidence_o      = result_q.coincidence;
  assign visible_line_o     = result_q.visible_line;
  assign lcd_irq_o          = result_q.lcd_irq;
  assign vblank_irq_o       = result_q.vblank_irq;
  assign draw_strobe_o      = result_q.draw_strobe;
  assign draw_line_number_o = result_q.draw_line_number;
  assign frame_complete_o   = result_q.frame_complete;

endmodule

/* sim/lcd_mode_and_line_timer_chk.sv */
// Scoreboard for the LCD mode and line timer: predicts every result and compares it.
`timescale 1ns / 1ps
module lcd_mode_and_line_timer_chk import lcdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,

  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [9:0]  cycles_i,
  input  logic        lcd_enable_i,
  input  logic [7:0]  compare_line_i,
  input  logic        irq_en_hblank_i,
  input  logic        irq_en_vblank_i,
  input  logic        irq_en_oam_i,
  input  logic        irq_en_match_i,

  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  mode_i,
  input  logic        coincidence_i,
  input  logic [7:0]  visible_line_i,
  input  logic        lcd_irq_i,
  input  logic        vblank_irq_i,
  input  logic        draw_strobe_i,
  input  logic [7:0]  draw_line_number_i,
  input  logic        frame_complete_i,

  output int          error_count_o,
  output int          pending_o
);

  localparam int MaxPrinted = 60;

  // Shadow copy of the timer state and of the two length registers.
  lcdt_mode_e                 mode_q;
  logic                       match_q;
  logic [7:0]                 line_q;
  logic signed [LineCdW-1:0]  line_cd_q;
  logic signed [FrameCdW-1:0] frame_cd_q;
  logic [LineLenW-1:0]        line_len_q;
  logic [FrameLenW-1:0]       frame_len_q;

  lcdt_result_t expected_results[$];
  int           mismatches;
  int           results_seen;

  assign error_count_o = mismatches;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  // Advances the shadow state by one tick and works out the result it gives.
  task automatic predict_tick(input lcdt_in_t tick, output lcdt_result_t res);
    int         ticks;
    int         line_cd;
    int         frame_cd;
    lcdt_mode_e prev_mode;
    res       = '0;
    ticks     = int'(tick.cycles >> 2);
    prev_mode = mode_q;

    // Both timers count down and saturate at the bottom of their signed range.
    line_cd = int'(line_cd_q) - ticks;
    if (line_cd < int'(LINE_CD_MIN)) line_cd = int'(LINE_CD_MIN);
    frame_cd = int'(frame_cd_q) - ticks;
    if (frame_cd < int'(FRAME_CD_MIN)) frame_cd = int'(FRAME_CD_MIN);

    if (tick.lcd_enable) begin
      if (line_q >= VBLANK_FIRST_LINE) begin
        mode_q = MODE_VBLANK;
      end else if (line_cd >= int'(OAM_START)) begin
        if (tick.irq_en_oam && prev_mode != MODE_OAM) res.lcd_irq = 1'b1;
        mode_q = MODE_OAM;
      end else if (line_cd >= int'(RENDER_END)) begin
        mode_q = MODE_RENDER;
      end else begin
        if (tick.irq_en_hblank && prev_mode != MODE_HBLANK) res.lcd_irq = 1'b1;
        mode_q = MODE_HBLANK;
      end
    end else begin
      mode_q = MODE_HBLANK;
    end

    // End of a line: draw strobe, end of frame on the last visible line,
    // then the next line, the coincidence flag and a single reload.
    if (line_cd <= 0) begin
      if (line_q <= LAST_VISIBLE_LINE) begin
        res.draw_strobe      = 1'b1;
        res.draw_line_number = line_q;
      end
      if (line_q == LAST_VISIBLE_LINE) begin
        res.frame_complete = 1'b1;
        if (tick.lcd_enable) begin
          res.vblank_irq = 1'b1;
          if (tick.irq_en_vblank) res.lcd_irq = 1'b1;
        end
      end
      line_q = line_q + 8'd1;
      if (tick.lcd_enable) begin
        match_q = (tick.compare_line == line_q);
        if (match_q && tick.irq_en_match) res.lcd_irq = 1'b1;
      end
      line_cd = int'(line_len_q) + line_cd;
    end

    if (frame_cd <= 0) begin
      line_q   = 8'd0;
      frame_cd = int'(frame_len_q) + frame_cd;
    end

    line_cd_q  = line_cd[LineCdW-1:0];
    frame_cd_q = frame_cd[FrameCdW-1:0];

    res.mode         = mode_q;
    res.coincidence  = match_q;
    res.visible_line = tick.lcd_enable ? line_q : 8'd0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lcdt_in_t     tick;
    lcdt_result_t want;
    if (!rst_ni) begin
      mode_q      = MODE_HBLANK;
      match_q     = 1'b0;
      line_q      = 8'd0;
      line_len_q  = LINE_LENGTH_RST;
      frame_len_q = FRAME_LENGTH_RST;
      line_cd_q   = {1'b0, LINE_LENGTH_RST};
      frame_cd_q  = {1'b0, FRAME_LENGTH_RST};
      expected_results.delete();
      pending_o   = 0;
    end else begin
      // The result leaving now belongs to an earlier tick, so it is checked
      // before the tick entering at this edge is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no tick outstanding",
                                    results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("mode", mode_i, want.mode);
          check_field("coincidence", coincidence_i, want.coincidence);
          check_field("visible_line", visible_line_i, want.visible_line);
          check_field("lcd_irq", lcd_irq_i, want.lcd_irq);
          check_field("vblank_irq", vblank_irq_i, want.vblank_irq);
          check_field("draw_strobe", draw_strobe_i, want.draw_strobe);
          check_field("draw_line_number", draw_line_number_i, want.draw_line_number);
          check_field("frame_complete", frame_complete_i, want.frame_complete);
        end
        results_seen++;
      end

      if (in_valid_i && !in_stall_i) begin
        tick.cycles        = cycles_i;
        tick.lcd_enable    = lcd_enable_i;
        tick.compare_line  = compare_line_i;
        tick.irq_en_hblank = irq_en_hblank_i;
        tick.irq_en_vblank = irq_en_vblank_i;
        tick.irq_en_oam    = irq_en_oam_i;
        tick.irq_en_match  = irq_en_match_i;
        predict_tick(tick, want);
        expected_results.push_back(want);
      end

      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LINE_LENGTH) begin
          line_len_q = cfg_wdata_i[LineLenW-1:0];
        end else begin
          frame_len_q = cfg_wdata_i[FrameLenW-1:0];
        end
      end

      pending_o = expected_results.size();
    end
  end

endmodule

/* sim/lcd_mode_and_line_timer_tb.sv */
// Testbench top for the LCD mode and line timer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module lcd_mode_and_line_timer_tb import lcdt_pkg::*;;

  // Generous bound on the whole run; a correct run needs a small fraction of it.
  localparam int unsigned CycleLimit  = 300000;
  // Length of the deliberate receiver hold-off, long enough to back up the block.
  localparam int          HoldCycles  = 300;
  // Quiet cycles after the last result has been taken.
  localparam int          DrainCycles = 8;
  localparam int          IdlePct     = 38;

  logic        clk_i;
  logic        rst_ni;

  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [16:0] cfg_wdata_i;

  logic        in_valid_i;
  logic        in_stall_o;
  logic [9:0]  cycles_i;
  logic        lcd_enable_i;
  logic [7:0]  compare_line_i;
  logic        irq_en_hblank_i;
  logic        irq_en_vblank_i;
  logic        irq_en_oam_i;
  logic        irq_en_match_i;

  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  mode_o;
  logic        coincidence_o;
  logic [7:0]  visible_line_o;
  logic        lcd_irq_o;
  logic        vblank_irq_o;
  logic        draw_strobe_o;
  logic [7:0]  draw_line_number_o;
  logic        frame_complete_o;

  int          error_count;
  int          pending;

  // Idle rates of the two sides, and the request for one long receiver hold-off.
  int          tx_idle_pct = IdlePct;
  int          rx_idle_pct = IdlePct;
  bit          hold_request = 1'b0;

  lcd_mode_and_line_timer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cycles_i          (cycles_i),
    .lcd_enable_i      (lcd_enable_i),
    .compare_line_i    (compare_line_i),
    .irq_en_hblank_i   (irq_en_hblank_i),
    .irq_en_vblank_i   (irq_en_vblank_i),
    .irq_en_oam_i      (irq_en_oam_i),
    .irq_en_match_i    (irq_en_match_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mode_o            (mode_o),
    .coincidence_o     (coincidence_o),
    .visible_line_o    (visible_line_o),
    .lcd_irq_o         (lcd_irq_o),
    .vblank_irq_o      (vblank_irq_o),
    .draw_strobe_o     (draw_strobe_o),
    .draw_line_number_o(draw_line_number_o),
    .frame_complete_o  (frame_complete_o)
  );

  // The scoreboard watches both channels and the configuration port on its own.
  lcd_mode_and_line_timer_chk i_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .cycles_i          (cycles_i),
    .lcd_enable_i      (lcd_enable_i),
    .compare_line_i    (compare_line_i),
    .irq_en_hblank_i   (irq_en_hblank_i),
    .irq_en_vblank_i   (irq_en_vblank_i),
    .irq_en_oam_i      (irq_en_oam_i),
    .irq_en_match_i    (irq_en_match_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mode_i            (mode_o),
    .coincidence_i     (coincidence_o),
    .visible_line_i    (visible_line_o),
    .lcd_irq_i         (lcd_irq_o),
    .vblank_irq_i      (vblank_irq_o),
    .draw_strobe_i     (draw_strobe_o),
    .draw_line_number_i(draw_line_number_o),
    .frame_complete_i  (frame_complete_o),
    .error_count_o     (error_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls at the configured rate. On request it stalls for a
  // long, counted stretch so that the output register fills and the block
  // pushes back on the sender.
  initial begin : receiver
    int hold_cnt;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cnt     = 0;
        while (hold_cnt < HoldCycles) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
          hold_cnt++;
        end
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic lcdt_in_t mk_tick(input logic [9:0] cyc, input logic lcd,
                                       input logic [7:0] cmp, input logic hbl,
                                       input logic vbl, input logic oam,
                                       input logic mat);
    lcdt_in_t t;
    t.cycles        = cyc;
    t.lcd_enable    = lcd;
    t.compare_line  = cmp;
    t.irq_en_hblank = hbl;
    t.irq_en_vblank = vbl;
    t.irq_en_oam    = oam;
    t.irq_en_match  = mat;
    return t;
  endfunction

  // Random tick with the cycle count drawn from the given window. The LCD is
  // mostly on, and half of the compare values sit on low lines so that the
  // coincidence flag actually sets now and then.
  function automatic lcdt_in_t random_tick(input int cyc_lo, input int cyc_hi);
    lcdt_in_t t;
    t.cycles        = 10'($urandom_range(cyc_hi, cyc_lo));
    t.lcd_enable    = ($urandom_range(99) < 90);
    t.compare_line  = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    t.irq_en_hblank = 1'($urandom_range(1));
    t.irq_en_vblank = 1'($urandom_range(1));
    t.irq_en_oam    = 1'($urandom_range(1));
    t.irq_en_match  = 1'($urandom_range(1));
    return t;
  endfunction

  // Offers one tick and returns at the edge where it is taken. Idle cycles are
  // inserted in front of it at random; the payload stays put while stalled.
  task automatic send_tick(input lcdt_in_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cycles_i        <= t.cycles;
    lcd_enable_i    <= t.lcd_enable;
    compare_line_i  <= t.compare_line;
    irq_en_hblank_i <= t.irq_en_hblank;
    irq_en_vblank_i <= t.irq_en_vblank;
    irq_en_oam_i    <= t.irq_en_oam;
    irq_en_match_i  <= t.irq_en_match;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops sending and waits until every outstanding result has been taken.
  // Every tick yields a result, so the block is idle once none is pending.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Lengths are only changed while the block is idle; both registers are
  // written back to back, one per cycle.
  task automatic set_lengths(input logic [9:0] line_len, input logic [16:0] frame_len);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_LINE_LENGTH;
    cfg_wdata_i <= {7'd0, line_len};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FRAME_LENGTH;
    cfg_wdata_i <= frame_len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_random_ticks(input int count, input int cyc_lo, input int cyc_hi);
    for (int n = 0; n < count; n++) begin
      send_tick(random_tick(cyc_lo, cyc_hi));
    end
  endtask

  initial begin : stimulus
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_LINE_LENGTH;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    cycles_i        <= '0;
    lcd_enable_i    <= 1'b0;
    compare_line_i  <= '0;
    irq_en_hblank_i <= 1'b0;
    irq_en_vblank_i <= 1'b0;
    irq_en_oam_i    <= 1'b0;
    irq_en_match_i  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through one line with the reset lengths: OAM entry with
    // its interrupt, rendering down to its lower bound, HBlank entry, a line
    // end with a compare match, then the same with the LCD off, where the
    // timers keep running but mode and interrupts stay quiet.
    send_tick(mk_tick(10'd0,    1'b1, 8'd0,   1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(10'd0,    1'b1, 8'd0,   1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(10'd400,  1'b1, 8'd0,   1'b1, 1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(10'd1023, 1'b1, 8'd255, 1'b0, 1'b1, 1'b0, 1'b1));
    send_tick(mk_tick(10'd64,   1'b1, 8'd0,   1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(10'd4,    1'b1, 8'd1,   1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(10'd3,    1'b1, 8'd1,   1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(10'd336,  1'b1, 8'd1,   1'b0, 1'b0, 1'b0, 1'b1));
    send_tick(mk_tick(10'd0,    1'b0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(10'd1023, 1'b0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(10'd1023, 1'b0, 8'd2,   1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(10'd0,    1'b1, 8'd255, 1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(10'd1023, 1'b1, 8'd255, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(10'd1023, 1'b1, 8'd3,   1'b1, 1'b0, 1'b0, 1'b1));
    send_tick(mk_tick(10'h155,  1'b1, 8'h55,  1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(10'h2AA,  1'b1, 8'hAA,  1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(10'd1023, 1'b1, 8'd0,   1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(10'd1023, 1'b1, 8'd5,   1'b1, 1'b1, 1'b1, 1'b1));

    // Reset lengths with the full cycle range.
    send_random_ticks(100, 0, 1023);

    // Longest lengths.
    set_lengths(10'd1023, 17'd131071);
    send_random_ticks(100, 0, 1023);

    // A line just long enough to show OAM scan, and a frame of 154 lines.
    // Large ticks carry the run through the last visible line, VBlank and
    // the frame wrap. At the start the receiver holds off for a long stretch
    // while ticks keep coming, so the block fills up and stalls its input.
    set_lengths(10'd380, 17'd58520);
    hold_request = 1'b1;
    send_random_ticks(330, 512, 1023);

    // Short lines in a very long frame: one line per tick, so the line
    // counter runs past 255 and wraps, and the line timer sinks to its floor.
    // This stretch runs with neither side idling.
    set_lengths(10'd30, 17'd131071);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_ticks(280, 0, 1023);
    tx_idle_pct = IdlePct;
    rx_idle_pct = IdlePct;

    // Shortest lengths with the largest ticks: every tick reloads both timers
    // and still leaves them negative, so the frame timer too reaches its floor.
    set_lengths(10'd1, 17'd1);
    send_random_ticks(530, 1020, 1023);

    // Climb back out of saturation under the reset lengths.
    set_lengths(LINE_LENGTH_RST, FRAME_LENGTH_RST);
    send_random_ticks(40, 0, 1023);

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
